// ----- rtl/core/lpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpc_pkg : shared types and constants of the line position centroid block
// Beat formats, register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package lpc_pkg;

    // Number of line sensors sampled in one scan (1 to 11)
    localparam int SENSOR_COUNT = 11;

    localparam int SAMPLE_W  = 8;
    localparam int WEIGHT_W  = 5;
    localparam int SUM_W     = 9;
    localparam int MAG_W     = 8;
    localparam int COUNT_W   = $clog2(SENSOR_COUNT + 1);
    localparam int IDX_W     = $clog2(SENSOR_COUNT + 1);
    localparam int MISS_W    = 8;
    localparam int DIV_STEPS = MAG_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int WLOW_W    = 30;
    localparam int WHIGH_W   = 25;
    localparam int WALL_W    = WLOW_W + WHIGH_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_HIGH = 2'd2;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST    = 8'd192;
    localparam logic [WLOW_W-1:0]   WEIGHTS_LOW_RST  = 30'd1007514392;
    localparam logic [WHIGH_W-1:0]  WEIGHTS_HIGH_RST = 25'd8593476;
    localparam logic [MISS_W-1:0]   MISS_MAX         = 8'd255;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                supply_flag;
    } sample_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] position;
        logic                       line_lost;
        logic [MISS_W-1:0]          miss_count;
        logic [SAMPLE_W-1:0]        supply_voltage;
    } result_t;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [MAG_W-1:0]   dividend;
        logic [COUNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [MAG_W-1:0]   quotient;
    } div_rsp_t;

endpackage

// ----- rtl/core/lpc_div.sv -----
// ----------------------------------------------------------------------------
// lpc_div : restoring unsigned divider, one quotient bit per cycle
// Divides the weight sum magnitude by the active sensor count.
// ----------------------------------------------------------------------------
module lpc_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  lpc_pkg::div_req_t req,
    output lpc_pkg::div_rsp_t rsp
);

    logic                          busy_reg;
    logic                          busy_next;
    logic                          done_reg;
    logic                          done_next;
    logic [lpc_pkg::STEP_W-1:0]    step_reg;
    logic [lpc_pkg::STEP_W-1:0]    step_next;
    logic [lpc_pkg::COUNT_W-1:0]   rem_reg;
    logic [lpc_pkg::COUNT_W-1:0]   rem_next;
    logic [lpc_pkg::MAG_W-1:0]     quo_reg;
    logic [lpc_pkg::MAG_W-1:0]     quo_next;
    logic [lpc_pkg::COUNT_W-1:0]   divisor_reg;
    logic [lpc_pkg::COUNT_W-1:0]   divisor_next;
    logic [lpc_pkg::COUNT_W:0]     trial;
    logic [lpc_pkg::COUNT_W:0]     diff;
    logic                          fits;

    // Shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[lpc_pkg::MAG_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[lpc_pkg::COUNT_W-1:0] : trial[lpc_pkg::COUNT_W-1:0];
            quo_next  = {quo_reg[lpc_pkg::MAG_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == lpc_pkg::STEP_W'(lpc_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- rtl/core/line_position_centroid.sv -----
// ----------------------------------------------------------------------------
// line_position_centroid : line position by weighted centroid of sensors
// Accumulates the weights of sensors above threshold over one scan and
// divides by their count on the supply beat that ends the scan.
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat payload                                  | handshake
//  ---------+-----+-----------------------------------------------+---------------------
//  sample   | in  | sample, supply_flag                           | sample_valid/ready
//  result   | out | position, line_lost, miss_count, supply_volt. | result_valid/ready
//  cfg      | in  | cfg_index, cfg_data                           | cfg_valid/ready
//
//  Sensor beats can follow back to back.
//  A supply beat is accepted and starts the one-bit-per-cycle divider;
//  its done flag hands the quotient over to the FSM, which then loads the
//  result register. A scan with no active sensor skips the divider and
//  goes straight to loading the result register.
//  The sample channel stays not ready while the divider runs and while a
//  finished result waits for a full result register to drain.
//  Reset clears the scan accumulators, miss counter and last position and
//  restores the register reset values; cfg_ready is always high.
//
module line_position_centroid
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  lpc_pkg::sample_t                    sample_data,
    output logic                                result_valid,
    input  logic                                result_ready,
    output lpc_pkg::result_t                    result_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers
    logic [lpc_pkg::SAMPLE_W-1:0]       threshold_reg;
    logic [lpc_pkg::WLOW_W-1:0]         weights_low_reg;
    logic [lpc_pkg::WHIGH_W-1:0]        weights_high_reg;

    // Scan state
    logic [lpc_pkg::IDX_W-1:0]          sensor_index_reg;
    logic [lpc_pkg::IDX_W-1:0]          sensor_index_next;
    logic signed [lpc_pkg::SUM_W-1:0]   weight_sum_reg;
    logic signed [lpc_pkg::SUM_W-1:0]   weight_sum_next;
    logic [lpc_pkg::COUNT_W-1:0]        active_count_reg;
    logic [lpc_pkg::COUNT_W-1:0]        active_count_next;
    logic [lpc_pkg::MISS_W-1:0]         misses_reg;
    logic [lpc_pkg::MISS_W-1:0]         misses_next;
    logic signed [lpc_pkg::WEIGHT_W-1:0] last_position_reg;
    logic signed [lpc_pkg::WEIGHT_W-1:0] last_position_next;
    logic [lpc_pkg::SAMPLE_W-1:0]       supply_reg;
    logic [lpc_pkg::SAMPLE_W-1:0]       supply_next;

    // Result register
    logic                               result_valid_reg;
    logic                               result_valid_next;
    lpc_pkg::result_t                   result_data_reg;
    lpc_pkg::result_t                   result_data_next;

    logic [lpc_pkg::WALL_W-1:0]         weights_all;
    logic signed [lpc_pkg::WEIGHT_W-1:0] weight_tab [lpc_pkg::SENSOR_COUNT];
    logic signed [lpc_pkg::WEIGHT_W-1:0] cur_weight;
    logic                               sample_fire;
    logic                               slot_open;
    logic                               sum_neg;
    logic [lpc_pkg::SUM_W-1:0]          sum_mag;
    logic [lpc_pkg::WEIGHT_W-1:0]       quo_low;
    logic signed [lpc_pkg::WEIGHT_W-1:0] new_position;

    lpc_pkg::div_req_t                  div_req;
    lpc_pkg::div_rsp_t                  div_rsp;

    lpc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready    = 1'b1;
    assign sample_ready = (state_reg == ST_IDLE);
    assign sample_fire  = sample_valid && sample_ready;
    assign slot_open    = !result_valid_reg || result_ready;

    // Unpack the per-sensor weights from the two weight registers
    assign weights_all = {weights_high_reg, weights_low_reg};

    always_comb
    begin
        for (int i = 0; i < lpc_pkg::SENSOR_COUNT; i++)
        begin
            weight_tab[i] = weights_all[lpc_pkg::WEIGHT_W*i +: lpc_pkg::WEIGHT_W];
        end
    end

    assign cur_weight = (sensor_index_reg < lpc_pkg::IDX_W'(lpc_pkg::SENSOR_COUNT))
                        ? weight_tab[sensor_index_reg] : '0;

    // Divide the magnitude, then restore the sign: truncation toward zero
    assign sum_neg      = weight_sum_reg[lpc_pkg::SUM_W-1];
    assign sum_mag      = sum_neg ? -weight_sum_reg : weight_sum_reg;
    assign quo_low      = div_rsp.quotient[lpc_pkg::WEIGHT_W-1:0];
    assign new_position = sum_neg ? -quo_low : quo_low;

    always_comb
    begin
        state_next         = state_reg;
        sensor_index_next  = sensor_index_reg;
        weight_sum_next    = weight_sum_reg;
        active_count_next  = active_count_reg;
        misses_next        = misses_reg;
        last_position_next = last_position_reg;
        supply_next        = supply_reg;
        result_valid_next  = result_valid_reg && !result_ready;
        result_data_next   = result_data_reg;
        div_req.start      = 1'b0;
        div_req.dividend   = sum_mag[lpc_pkg::MAG_W-1:0];
        div_req.divisor    = active_count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_fire)
                begin
                    if (sample_data.supply_flag)
                    begin
                        // End of scan: hold the supply beat, start the divide if any sensor was active
                        supply_next = sample_data.sample;
                        if (active_count_reg != '0)
                        begin
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else if (sensor_index_reg < lpc_pkg::IDX_W'(lpc_pkg::SENSOR_COUNT))
                    begin
                        if (sample_data.sample > threshold_reg)
                        begin
                            weight_sum_next = weight_sum_reg
                                + {{(lpc_pkg::SUM_W-lpc_pkg::WEIGHT_W){cur_weight[lpc_pkg::WEIGHT_W-1]}},
                                   cur_weight};
                            active_count_next = active_count_reg + 1'b1;
                        end
                        sensor_index_next = sensor_index_reg + 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Load the result once the result register can take it
                if (slot_open)
                begin
                    result_valid_next             = 1'b1;
                    result_data_next.supply_voltage = supply_reg;
                    if (active_count_reg == '0)
                    begin
                        if (misses_reg != lpc_pkg::MISS_MAX)
                        begin
                            misses_next = misses_reg + 1'b1;
                        end
                        result_data_next.position   = last_position_reg;
                        result_data_next.line_lost  = 1'b1;
                        result_data_next.miss_count = (misses_reg != lpc_pkg::MISS_MAX)
                                                      ? misses_reg + 1'b1 : misses_reg;
                    end
                    else
                    begin
                        misses_next                 = '0;
                        last_position_next          = new_position;
                        result_data_next.position   = new_position;
                        result_data_next.line_lost  = 1'b0;
                        result_data_next.miss_count = '0;
                    end
                    sensor_index_next = '0;
                    weight_sum_next   = '0;
                    active_count_next = '0;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            sensor_index_reg  <= '0;
            weight_sum_reg    <= '0;
            active_count_reg  <= '0;
            misses_reg        <= '0;
            last_position_reg <= '0;
            result_valid_reg  <= 1'b0;
            threshold_reg     <= lpc_pkg::THRESHOLD_RST;
            weights_low_reg   <= lpc_pkg::WEIGHTS_LOW_RST;
            weights_high_reg  <= lpc_pkg::WEIGHTS_HIGH_RST;
        end
        else
        begin
            state_reg         <= state_next;
            sensor_index_reg  <= sensor_index_next;
            weight_sum_reg    <= weight_sum_next;
            active_count_reg  <= active_count_next;
            misses_reg        <= misses_next;
            last_position_reg <= last_position_next;
            result_valid_reg  <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lpc_pkg::REG_THRESHOLD:
                        threshold_reg <= cfg_data[lpc_pkg::SAMPLE_W-1:0];
                    lpc_pkg::REG_WEIGHTS_LOW:
                        weights_low_reg <= cfg_data[lpc_pkg::WLOW_W-1:0];
                    lpc_pkg::REG_WEIGHTS_HIGH:
                        weights_high_reg <= cfg_data[lpc_pkg::WHIGH_W-1:0];
                    default:
                    begin
                        // Drop writes to unmapped indexes
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        supply_reg      <= supply_next;
        result_data_reg <= result_data_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

endmodule

// ----- rtl/core/lpc_checker.sv -----
// ----------------------------------------------------------------------------
// lpc_checker : port-level checks of the line position centroid block
// Watches the sample and result channels and the miss counter.
// ----------------------------------------------------------------------------
module lpc_checker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    input  logic             sample_ready,
    input  lpc_pkg::sample_t sample_data,
    input  logic             result_valid,
    input  logic             result_ready,
    input  lpc_pkg::result_t result_data
);

    // A stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_data))
        else $error("result payload changed while stalled");

    // A lost-line result always counts at least one miss
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.line_lost |-> result_data.miss_count != 8'd0)
        else $error("lost line with zero miss count");

    // A found-line result clears the miss counter
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.line_lost |-> result_data.miss_count == 8'd0)
        else $error("found line with nonzero miss count");

    // The supply beat ends the scan and blocks the sample channel next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && sample_data.supply_flag |=> !sample_ready)
        else $error("sample channel ready right after supply beat");

endmodule

bind line_position_centroid lpc_checker u_lpc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for line_position_centroid
// Streams sensor and supply beats through the sample channel under random
// gaps and result stalls. An in-bench copy of the centroid arithmetic
// predicts each scan result, and every result beat is compared against it.
// ----------------------------------------------------------------------------
module tb_top;

    import lpc_pkg::*;

    // Idle time after the last result before a register write or the verdict.
    // Covers a sensor beat still in flight plus the supply path through the divider.
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 700;
    localparam int MIN_RESULTS   = 48;
    // Index that maps to no register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    // ------------------------------------------------------------------------
    // Scan predictor and store of pending scan results
    // ------------------------------------------------------------------------
    class centroid_scoreboard;
        logic [SAMPLE_W-1:0]        threshold;
        logic [WLOW_W-1:0]          weights_low;
        logic [WHIGH_W-1:0]         weights_high;
        int                         sensor_index;
        int                         weight_sum;
        int                         active_count;
        int                         misses;
        logic signed [WEIGHT_W-1:0] last_position;
        result_t                    scan_results_due[$];
        int unsigned                mismatches;
        int unsigned                samples_taken;
        int unsigned                results_seen;

        function new();
            threshold     = THRESHOLD_RST;
            weights_low   = WEIGHTS_LOW_RST;
            weights_high  = WEIGHTS_HIGH_RST;
            sensor_index  = 0;
            weight_sum    = 0;
            active_count  = 0;
            misses        = 0;
            last_position = '0;
            mismatches    = 0;
            samples_taken = 0;
            results_seen  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_THRESHOLD:    threshold    = data[SAMPLE_W-1:0];
                REG_WEIGHTS_LOW:  weights_low  = data[WLOW_W-1:0];
                REG_WEIGHTS_HIGH: weights_high = data[WHIGH_W-1:0];
                default:          ;
            endcase
        endfunction

        function int sensor_weight(int idx);
            logic signed [WEIGHT_W-1:0] w;
            if (idx < 6)
                w = weights_low[WEIGHT_W*idx +: WEIGHT_W];
            else
                w = weights_high[WEIGHT_W*(idx-6) +: WEIGHT_W];
            return int'(w);
        endfunction

        // Fold one accepted sample beat into the scan; a supply beat closes it
        function void take_sample(sample_t beat);
            result_t                    due;
            logic signed [WEIGHT_W-1:0] centroid;
            samples_taken++;
            if (!beat.supply_flag)
            begin
                if (sensor_index < SENSOR_COUNT)
                begin
                    if (beat.sample > threshold)
                    begin
                        weight_sum += sensor_weight(sensor_index);
                        active_count++;
                    end
                    sensor_index++;
                end
                return;
            end
            if (active_count == 0)
            begin
                due.line_lost = 1'b1;
                due.position  = last_position;
                if (misses < MISS_MAX)
                    misses++;
            end
            else
            begin
                // SV integer division truncates toward zero
                centroid      = WEIGHT_W'(weight_sum / active_count);
                due.line_lost = 1'b0;
                due.position  = centroid;
                misses        = 0;
                last_position = centroid;
            end
            due.miss_count     = MISS_W'(misses);
            due.supply_voltage = beat.sample;
            scan_results_due.push_back(due);
            sensor_index = 0;
            weight_sum   = 0;
            active_count = 0;
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (scan_results_due.size() == 0)
            begin
                $error("unexpected result beat: position %0d, line_lost %0d, miss_count %0d",
                       $signed(got.position), got.line_lost, got.miss_count);
                mismatches++;
                return;
            end
            want = scan_results_due.pop_front();
            if (got.position !== want.position)
            begin
                $error("position: expected %0d, actual %0d",
                       $signed(want.position), $signed(got.position));
                mismatches++;
            end
            if (got.line_lost !== want.line_lost)
            begin
                $error("line_lost: expected %0d, actual %0d", want.line_lost, got.line_lost);
                mismatches++;
            end
            if (got.miss_count !== want.miss_count)
            begin
                $error("miss_count: expected %0d, actual %0d", want.miss_count, got.miss_count);
                mismatches++;
            end
            if (got.supply_voltage !== want.supply_voltage)
            begin
                $error("supply_voltage: expected %0d, actual %0d",
                       want.supply_voltage, got.supply_voltage);
                mismatches++;
            end
        endfunction

        function int pending();
            return scan_results_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    sample_t               sample_data  = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result_data;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    centroid_scoreboard board;
    int                 cycle_count = 0;
    int                 stall_left  = 0;
    // Burst modes turn idling off on one side for a whole phase
    bit                 send_burst  = 1'b0;
    bit                 take_burst  = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    line_position_centroid u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: check every accepted beat, stall ready at random
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_result(result_data);
        if (take_burst)
            result_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= pick_gap();
        end
        else
            result_ready <= 1'b1;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Present one sample beat and hold it until accepted. With no gap, valid
    // stays high so the next call lines up its beat in the same time step.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic flag);
        sample_t beat;
        int      gap;
        beat.sample      = value;
        beat.supply_flag = flag;
        sample_valid <= 1'b1;
        sample_data  <= beat;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        board.take_sample(beat);
        gap = send_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait out every pending scan result, then let the core settle
    task automatic settle();
        sample_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sensor level biased to land above the threshold with the given percent,
    // with a few hits exactly on the threshold
    function automatic logic [SAMPLE_W-1:0] pick_level(int density);
        int thr;
        thr = board.threshold;
        if ($urandom_range(0, 99) < 5)
            return SAMPLE_W'(thr);
        if ($urandom_range(0, 99) < density && thr < 255)
            return SAMPLE_W'($urandom_range(thr + 1, 255));
        return SAMPLE_W'($urandom_range(0, thr));
    endfunction

    // Mostly full scans; some short, some with extra sensor beats, some blind
    task automatic random_scan();
        int n;
        int r;
        int density;
        r = $urandom_range(0, 99);
        if (r < 75)
            n = SENSOR_COUNT;
        else if (r < 88)
            n = $urandom_range(0, SENSOR_COUNT - 1);
        else
            n = $urandom_range(SENSOR_COUNT + 1, SENSOR_COUNT + 3);
        density = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 100);
        for (int i = 0; i < n; i++)
            send_sample(pick_level(density), 1'b0);
        send_sample(SAMPLE_W'($urandom_range(0, 255)), 1'b1);
    endtask

    // New register settings; extremes turn up often. Upper data bits beyond a
    // register's width are randomized as well and must be ignored.
    task automatic random_config();
        logic [CFG_DATA_W-1:0] data;
        int                    r;
        data = CFG_DATA_W'($urandom());
        r    = $urandom_range(0, 9);
        if (r == 0)
            data[SAMPLE_W-1:0] = '0;
        else if (r == 1)
            data[SAMPLE_W-1:0] = '1;
        cfg_write(REG_THRESHOLD, data);
        r = $urandom_range(0, 9);
        if (r == 0)
            cfg_write(REG_WEIGHTS_LOW, {6{5'b10000}});
        else if (r == 1)
            cfg_write(REG_WEIGHTS_LOW, {6{5'b01111}});
        else
            cfg_write(REG_WEIGHTS_LOW, CFG_DATA_W'($urandom()));
        r = $urandom_range(0, 9);
        if (r == 0)
            cfg_write(REG_WEIGHTS_HIGH, CFG_DATA_W'({5{5'b10000}}));
        else if (r == 1)
            cfg_write(REG_WEIGHTS_HIGH, CFG_DATA_W'({5{5'b01111}}));
        else
            cfg_write(REG_WEIGHTS_HIGH, CFG_DATA_W'($urandom()));
        if ($urandom_range(0, 7) == 0)
            cfg_write(REG_UNMAPPED, CFG_DATA_W'($urandom()));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values. Sensor 0 one above threshold, sensor 1 on
        // it, sensor 4 dark, one surplus sensor beat that must be dropped.
        send_sample(8'd193, 1'b0);
        send_sample(8'd192, 1'b0);
        for (int i = 2; i < SENSOR_COUNT; i++)
            send_sample((i == 4) ? 8'd0 : 8'd255, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b1);
        // Empty scan: line lost, previous position repeated
        send_sample(8'd255, 1'b1);
        // Short scan with one bright sensor, then lost again holding it
        send_sample(8'd255, 1'b0);
        send_sample(8'd170, 1'b1);
        send_sample(8'd85, 1'b1);
        settle();

        // Lowest threshold, every weight at its negative extreme
        cfg_write(REG_THRESHOLD, CFG_DATA_W'(0));
        cfg_write(REG_WEIGHTS_LOW, {6{5'b10000}});
        cfg_write(REG_WEIGHTS_HIGH, CFG_DATA_W'({5{5'b10000}}));
        for (int i = 0; i < SENSOR_COUNT; i++)
            send_sample(8'd1, 1'b0);
        send_sample(8'd0, 1'b1);
        settle();

        // Threshold one below full scale, every weight at its positive extreme
        cfg_write(REG_THRESHOLD, CFG_DATA_W'(254));
        cfg_write(REG_WEIGHTS_LOW, {6{5'b01111}});
        cfg_write(REG_WEIGHTS_HIGH, CFG_DATA_W'({5{5'b01111}}));
        for (int i = 0; i < SENSOR_COUNT; i++)
            send_sample(8'd255, 1'b0);
        send_sample(8'd255, 1'b1);
        settle();

        // Full-scale threshold: nothing can be seen. Run enough blind scans
        // to drive the miss counter into saturation.
        cfg_write(REG_THRESHOLD, CFG_DATA_W'(255));
        send_burst = 1'b1;
        for (int i = 0; i < 270; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_sample(8'd255, 1'b0);
            send_sample(SAMPLE_W'($urandom_range(0, 255)), 1'b1);
        end
        send_burst = 1'b0;
        // Hold the sender until every blind result has drained
        settle();

        // Random phases with fresh settings between them
        while (board.samples_taken < RANDOM_ITEMS || board.results_seen < MIN_RESULTS)
        begin
            random_config();
            send_burst = ($urandom_range(0, 3) == 0);
            take_burst = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 12)) random_scan();
            settle();
        end

        if (board.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
